// ===== rtl/ldps_pkg.sv =====
package ldps_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TickMs = 10;

  // Input actions
  localparam logic [1:0] ACT_TAIL  = 2'd0;
  localparam logic [1:0] ACT_BRAKE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_INIT  = 2'd3;

  // Driver phases
  localparam logic [1:0] PH_DISABLED  = 2'd0;
  localparam logic [1:0] PH_ENABLING  = 2'd1;
  localparam logic [1:0] PH_ENABLED   = 2'd2;
  localparam logic [1:0] PH_DISABLING = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BRIGHT_MIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BRIGHT_MAX  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PWM_PERIOD  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ON_DELAY    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OFF_DELAY   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_TMO    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SHUTDOWN_EN = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_START_EN    = 3'd7;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] level;
    logic [DataW-1:0] period;
    logic [DataW-1:0] divisor;
  } scale_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DataW-1:0] value;
  } scale_rsp_t;

endpackage

// ===== rtl/ldps_scale.sv =====
module ldps_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ldps_pkg::scale_req_t req_i,
  output ldps_pkg::scale_rsp_t rsp_o
);
  import ldps_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_CHK  = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  localparam int unsigned CntW = $clog2(DataW);

  logic [1:0]         state_q, state_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [DataW-1:0]   lvl_q, lvl_d;
  logic [DataW-1:0]   per_q, per_d;
  logic [DataW-1:0]   div_q, div_d;
  logic [2*DataW-1:0] prod_q, prod_d;
  logic [DataW-1:0]   rem_q, rem_d;
  logic [DataW-1:0]   quo_q, quo_d;
  logic [DataW:0]     trial;
  logic               fits;

  // One restoring step: shift the next dividend bit into the remainder.
  assign trial = {rem_q, quo_q[DataW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    lvl_d   = lvl_q;
    per_d   = per_q;
    div_d   = div_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          lvl_d   = req_i.level;
          per_d   = req_i.period;
          div_d   = req_i.divisor;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = lvl_q * per_q;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        // High half at or above the divisor means the quotient overflows;
        // a zero divisor lands here too.
        if (prod_q[2*DataW-1:DataW] >= div_q) begin
          quo_d   = '1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          rem_d   = prod_q[2*DataW-1:DataW];
          quo_d   = prod_q[DataW-1:0];
          cnt_d   = '1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = fits ? DataW'(trial - {1'b0, div_q}) : trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], fits};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q  <= lvl_d;
    per_q  <= per_d;
    div_q  <= div_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.busy  = state_q != ST_IDLE;
  assign rsp_o.done  = done_q;
  assign rsp_o.value = quo_q;

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.start && state_q == ST_IDLE) |=> rsp_o.busy)
    else $error("scale unit did not start");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE)
    else $error("scale done while still busy");
  a_div_from_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && $past(state_q) != ST_DIV) |-> $past(state_q) == ST_CHK)
    else $error("division entered without overflow check");
`endif

endmodule

// ===== rtl/led_driver_power_sequencer_unit.sv =====
// The result of a request needing no duty scaling is loaded into the output register once
// the output slot is free; a tick that rescales the PWM compare value first runs a multiply,
// an overflow check and, unless it saturates, 16 restoring divide steps, one bit each.
// Throughput: one request at a time; the next request is taken once the result of the
// previous one has been moved into the output register.
// Reset: asynchronous active low; clears phase, levels, timers, flags and compare value
// and loads the register defaults.
module led_driver_power_sequencer_unit #(
  parameter int unsigned LEVEL_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [ldps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ldps_pkg::DataW-1:0]    cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    in_action_i,
  input  logic [ldps_pkg::DataW-1:0]    in_brightness_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    out_phase_o,
  output logic                          out_driver_on_o,
  output logic                          out_dim_pwm_active_o,
  output logic [ldps_pkg::DataW-1:0]    out_duty_compare_o
);
  import ldps_pkg::*;

  // Configuration registers
  logic [DataW-1:0] bmin_q, bmax_q, period_q, on_dly_q, off_dly_q, idle_tmo_q;
  logic             shut_en_q, start_en_q;

  // Sequencer state
  logic [1:0]             phase_q, phase_d;
  logic [LEVEL_WIDTH-1:0] tail_q, tail_d, brake_q, brake_d;
  logic                   seen_q, seen_d, started_q, started_d;
  logic [DataW-1:0]       elapsed_q, elapsed_d, idle_q, idle_d;
  logic                   drv_q, drv_d, dim_q, dim_d;
  logic [DataW-1:0]       cmp_q, cmp_d;

  // Result handshake
  logic                   pend_q, pend_d;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             res_phase_q;
  logic                   res_drv_q, res_dim_q;
  logic [DataW-1:0]       res_cmp_q;

  logic                   accept, load;
  logic [DataW-1:0]       clamped, target, limited, elapsed_inc, idle_next;
  logic [DataW:0]         elapsed_sum;
  scale_req_t             scale_req;
  scale_rsp_t             scale_rsp;

  // Hold off new requests until the current result has reached the output register.
  assign in_stall_o = pend_q;
  assign accept     = in_valid_i && !pend_q;
  // Move the finished result out once scaling is over and the output slot is free.
  assign load       = pend_q && !scale_rsp.busy && !scale_rsp.done &&
                      (!out_valid_q || !out_stall_i);

  assign clamped = (in_brightness_i > bmax_q) ? bmax_q : in_brightness_i;
  assign target  = (brake_q > tail_q) ? DataW'(brake_q) : DataW'(tail_q);
  assign limited = (target > bmax_q) ? bmax_q : target;

  // Saturating delay timer advance
  assign elapsed_sum = {1'b0, elapsed_q} + (DataW + 1)'(TickMs);
  assign elapsed_inc = elapsed_sum[DataW] ? '1 : elapsed_sum[DataW-1:0];
  assign idle_next   = (idle_q >= DataW'(TickMs)) ? idle_q - DataW'(TickMs) : '0;

  always_comb begin
    phase_d   = phase_q;
    tail_d    = tail_q;
    brake_d   = brake_q;
    seen_d    = seen_q;
    started_d = started_q;
    elapsed_d = elapsed_q;
    idle_d    = idle_q;
    drv_d     = drv_q;
    dim_d     = dim_q;
    cmp_d     = cmp_q;
    scale_req.start   = 1'b0;
    scale_req.level   = bmin_q;
    scale_req.period  = period_q;
    scale_req.divisor = bmax_q;

    // Pick up the scaled compare value as soon as the unit finishes.
    if (scale_rsp.done) begin
      cmp_d = scale_rsp.value;
    end

    if (accept) begin
      unique case (in_action_i) inside
        ACT_TAIL, ACT_BRAKE: begin
          if (in_action_i == ACT_TAIL) begin
            tail_d = clamped[LEVEL_WIDTH-1:0];
          end else begin
            brake_d = clamped[LEVEL_WIDTH-1:0];
          end
          seen_d = 1'b1;
        end
        ACT_TICK: begin
          unique case (phase_q)
            PH_DISABLED: begin
              if (target > bmin_q) begin
                drv_d     = 1'b1;
                phase_d   = PH_ENABLING;
                elapsed_d = '0;
                if (!started_q) begin
                  scale_req.start = 1'b1;
                  started_d       = 1'b1;
                end
              end
            end
            PH_ENABLING: begin
              elapsed_d = elapsed_inc;
              if (elapsed_inc >= on_dly_q && seen_q) begin
                dim_d   = 1'b1;
                phase_d = PH_ENABLED;
                if (!started_q) begin
                  scale_req.start = 1'b1;
                  started_d       = 1'b1;
                end
              end
            end
            PH_ENABLED: begin
              if (limited > bmin_q) begin
                dim_d           = 1'b1;
                scale_req.start = 1'b1;
                scale_req.level = limited;
              end else begin
                dim_d = 1'b0;
              end
              // Reload the idle timer while lit, otherwise count it down to zero.
              idle_d = (target > bmin_q) ? idle_tmo_q : idle_next;
              if (shut_en_q && idle_d == '0) begin
                drv_d     = 1'b0;
                phase_d   = PH_DISABLING;
                elapsed_d = '0;
              end
            end
            PH_DISABLING: begin
              elapsed_d = elapsed_inc;
              if (elapsed_inc >= off_dly_q) begin
                phase_d = PH_DISABLED;
              end
            end
            default: phase_d = PH_DISABLED;
          endcase
        end
        ACT_INIT: begin
          tail_d    = bmin_q[LEVEL_WIDTH-1:0];
          brake_d   = bmin_q[LEVEL_WIDTH-1:0];
          phase_d   = start_en_q ? PH_ENABLING : PH_DISABLING;
          elapsed_d = '0;
        end
        default: phase_d = phase_q;
      endcase
    end

    pend_d      = accept ? 1'b1 : (load ? 1'b0 : pend_q);
    out_valid_d = load ? 1'b1 : ((out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q);
  end

  ldps_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scale_req),
    .rsp_o  (scale_rsp)
  );

  // Configuration writes; the user must issue them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bmin_q     <= '0;
      bmax_q     <= DataW'(1000);
      period_q   <= DataW'(1000);
      on_dly_q   <= DataW'(10);
      off_dly_q  <= DataW'(10);
      idle_tmo_q <= DataW'(1000);
      shut_en_q  <= 1'b1;
      start_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BRIGHT_MIN:  bmin_q     <= cfg_wdata_i;
        CFG_BRIGHT_MAX:  bmax_q     <= cfg_wdata_i;
        CFG_PWM_PERIOD:  period_q   <= cfg_wdata_i;
        CFG_ON_DELAY:    on_dly_q   <= cfg_wdata_i;
        CFG_OFF_DELAY:   off_dly_q  <= cfg_wdata_i;
        CFG_IDLE_TMO:    idle_tmo_q <= cfg_wdata_i;
        CFG_SHUTDOWN_EN: shut_en_q  <= cfg_wdata_i[0];
        CFG_START_EN:    start_en_q <= cfg_wdata_i[0];
        default:         bmin_q     <= bmin_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DISABLED;
      tail_q      <= '0;
      brake_q     <= '0;
      seen_q      <= 1'b0;
      started_q   <= 1'b0;
      elapsed_q   <= '0;
      idle_q      <= '0;
      drv_q       <= 1'b0;
      dim_q       <= 1'b0;
      cmp_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tail_q      <= tail_d;
      brake_q     <= brake_d;
      seen_q      <= seen_d;
      started_q   <= started_d;
      elapsed_q   <= elapsed_d;
      idle_q      <= idle_d;
      drv_q       <= drv_d;
      dim_q       <= dim_d;
      cmp_q       <= cmp_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register: snapshot of the state after the request.
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_phase_q <= phase_q;
      res_drv_q   <= drv_q;
      res_dim_q   <= dim_q;
      res_cmp_q   <= cmp_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_phase_o          = res_phase_q;
  assign out_driver_on_o      = res_drv_q;
  assign out_dim_pwm_active_o = res_dim_q;
  assign out_duty_compare_o   = res_cmp_q;

`ifndef ASSERT_OFF
  a_accept_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_q)
    else $error("accepted request left no pending result");
  a_scale_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scale_rsp.busy || scale_rsp.done) |-> pend_q)
    else $error("scale unit active with no request in flight");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_rsp.busy |-> !load)
    else $error("result loaded before scaling finished");
  a_load_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_o && !pend_q))
    else $error("result load did not fill output register");
`endif

endmodule

// ===== sim/led_driver_power_sequencer_unit_test.sv =====
module led_driver_power_sequencer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ldps_pkg::*;

  localparam int unsigned LEVEL_WIDTH   = 16;
  localparam logic [DataW-1:0] LevelMask = DataW'((1 << LEVEL_WIDTH) - 1);
  // Extra settling after the last result, before touching registers.
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned RANDOM_ITEMS  = 1000;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [1:0]       phase;
    logic             driver_on;
    logic             dim_active;
    logic [DataW-1:0] duty;
  } drv_status_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DataW-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         in_action_i;
  logic [DataW-1:0]   in_brightness_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         out_phase_o;
  logic               out_driver_on_o;
  logic               out_dim_pwm_active_o;
  logic [DataW-1:0]   out_duty_compare_o;

  led_driver_power_sequencer_unit #(
    .LEVEL_WIDTH(LEVEL_WIDTH)
  ) u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_action_i         (in_action_i),
    .in_brightness_i     (in_brightness_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_phase_o         (out_phase_o),
    .out_driver_on_o     (out_driver_on_o),
    .out_dim_pwm_active_o(out_dim_pwm_active_o),
    .out_duty_compare_o  (out_duty_compare_o)
  );

  always #10 clk_i = ~clk_i;

  // Register copy, loaded with the reset defaults.
  logic [DataW-1:0] reg_min      = 16'd0;
  logic [DataW-1:0] reg_max      = 16'd1000;
  logic [DataW-1:0] reg_period   = 16'd1000;
  logic [DataW-1:0] reg_on_dly   = 16'd10;
  logic [DataW-1:0] reg_off_dly  = 16'd10;
  logic [DataW-1:0] reg_idle     = 16'd1000;
  bit               reg_shutdown = 1'b1;
  bit               reg_start    = 1'b0;

  // Sequencer state as the driver should see it; all clear after reset.
  logic [1:0]       seq_phase     = PH_DISABLED;
  logic [DataW-1:0] tail_lvl      = '0;
  logic [DataW-1:0] brake_lvl     = '0;
  bit               setpoint_seen = 1'b0;
  bit               pwm_started   = 1'b0;
  logic [DataW-1:0] elapsed_ms    = '0;
  logic [DataW-1:0] countdown_ms  = '0;
  bit               drv_on        = 1'b0;
  bit               dim_on        = 1'b0;
  logic [DataW-1:0] compare_val   = '0;

  drv_status_t driver_status_q[$];
  int unsigned sent_count  = 0;
  int unsigned fail_count  = 0;
  bit          steady_flow = 1'b0;
  int unsigned hold_cnt    = 0;
  int unsigned free_cnt    = 0;

  // Compare value for a level: level * period / max, saturated, all ones on a zero max.
  function automatic logic [DataW-1:0] scaled_duty(input logic [DataW-1:0] level);
    logic [63:0] prod;
    logic [63:0] quot;
    if (reg_max == '0) return 16'hFFFF;
    prod = 64'(level) * 64'(reg_period);
    quot = prod / 64'(reg_max);
    return (quot > 64'hFFFF) ? 16'hFFFF : quot[DataW-1:0];
  endfunction

  // Advance the turn-on/turn-off timer by one tick and report whether it ran out.
  function automatic bit delay_reached(input logic [DataW-1:0] limit);
    logic [DataW:0] sum;
    sum = {1'b0, elapsed_ms} + (DataW + 1)'(TickMs);
    elapsed_ms = sum[DataW] ? 16'hFFFF : sum[DataW-1:0];
    return elapsed_ms >= limit;
  endfunction

  // The compare value is seeded from the minimum only on the very first start.
  function automatic void begin_pwm();
    if (!pwm_started) begin
      compare_val = scaled_duty(reg_min);
      pwm_started = 1'b1;
    end
  endfunction

  // Apply one request to the sequencer state and return the status it leaves behind.
  function automatic drv_status_t step_sequencer(input logic [1:0] act,
                                                 input logic [DataW-1:0] lvl);
    logic [DataW-1:0] clamped;
    logic [DataW-1:0] target;
    logic [DataW-1:0] capped;
    drv_status_t      st;
    clamped = (lvl > reg_max) ? reg_max : lvl;
    target  = (brake_lvl > tail_lvl) ? brake_lvl : tail_lvl;
    case (act)
      ACT_TAIL: begin
        tail_lvl      = clamped & LevelMask;
        setpoint_seen = 1'b1;
      end
      ACT_BRAKE: begin
        brake_lvl     = clamped & LevelMask;
        setpoint_seen = 1'b1;
      end
      ACT_TICK: begin
        case (seq_phase)
          PH_DISABLED: begin
            if (target > reg_min) begin
              drv_on = 1'b1;
              begin_pwm();
              seq_phase  = PH_ENABLING;
              elapsed_ms = '0;
            end
          end
          PH_ENABLING: begin
            if (delay_reached(reg_on_dly) && setpoint_seen) begin
              begin_pwm();
              dim_on    = 1'b1;
              seq_phase = PH_ENABLED;
            end
          end
          PH_ENABLED: begin
            capped = (target > reg_max) ? reg_max : target;
            if (capped > reg_min) begin
              dim_on      = 1'b1;
              compare_val = scaled_duty(capped);
            end else begin
              dim_on = 1'b0;
            end
            // Reload while lit, otherwise count down and stop at zero.
            if (target > reg_min) begin
              countdown_ms = reg_idle;
            end else if (countdown_ms != '0) begin
              countdown_ms = (countdown_ms >= TickMs) ? DataW'(countdown_ms - TickMs) : '0;
            end
            if (reg_shutdown && countdown_ms == '0) begin
              drv_on     = 1'b0;
              seq_phase  = PH_DISABLING;
              elapsed_ms = '0;
            end
          end
          default: begin
            if (delay_reached(reg_off_dly)) seq_phase = PH_DISABLED;
          end
        endcase
      end
      default: begin
        tail_lvl   = reg_min & LevelMask;
        brake_lvl  = reg_min & LevelMask;
        seq_phase  = reg_start ? PH_ENABLING : PH_DISABLING;
        elapsed_ms = '0;
      end
    endcase
    st.phase      = seq_phase;
    st.driver_on  = drv_on;
    st.dim_active = dim_on;
    st.duty       = compare_val;
    return st;
  endfunction

  function automatic void note_failure(input string msg);
    if (fail_count < REPORT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endfunction

  // Mostly short gaps, now and then a long one; none at all during steady stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DataW-1:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return DataW'($urandom());
      1:       return reg_max;
      2:       return reg_min + 16'd1;
      3:       return 16'hFFFF;
      default: return DataW'($urandom_range(0, reg_max));
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_scale_value();
    case ($urandom_range(0, 9))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2, 3:    return DataW'($urandom_range(1, 65535));
      default: return DataW'($urandom_range(100, 2000));
    endcase
  endfunction

  // Output side: alternate free runs and stalls of random length.
  always @(negedge clk_i) begin
    if (hold_cnt != 0) begin
      out_stall_i <= 1'b1;
      hold_cnt--;
    end else if (free_cnt != 0) begin
      out_stall_i <= 1'b0;
      free_cnt--;
    end else begin
      out_stall_i <= 1'b0;
      free_cnt = $urandom_range(0, 6);
      hold_cnt = pick_gap();
    end
  end

  // Check every accepted result against the oldest pending status.
  always @(posedge clk_i) begin : check_results
    drv_status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (driver_status_q.size() == 0) begin
        note_failure("result with no request outstanding");
      end else begin
        want = driver_status_q.pop_front();
        if (out_phase_o !== want.phase)
          note_failure($sformatf("phase exp %0d got %0d", want.phase, out_phase_o));
        if (out_driver_on_o !== want.driver_on)
          note_failure($sformatf("driver_on exp %0b got %0b", want.driver_on,
                                 out_driver_on_o));
        if (out_dim_pwm_active_o !== want.dim_active)
          note_failure($sformatf("dim_pwm_active exp %0b got %0b", want.dim_active,
                                 out_dim_pwm_active_o));
        if (out_duty_compare_o !== want.duty)
          note_failure($sformatf("duty_compare exp %0d got %0d", want.duty,
                                 out_duty_compare_o));
      end
    end
  end

  // Offer one request after a random gap, hold it until accepted, then predict.
  task automatic send_request(input logic [1:0] act, input logic [DataW-1:0] lvl);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_action_i     <= act;
    in_brightness_i <= lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    driver_status_q.push_back(step_sequencer(act, lvl));
    sent_count++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every outstanding request has produced its result.
  task automatic await_idle();
    in_valid_i <= 1'b0;
    while (driver_status_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write one register and drop the enable again before returning, so enables never overlap.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_BRIGHT_MIN:  reg_min      = val;
      CFG_BRIGHT_MAX:  reg_max      = val;
      CFG_PWM_PERIOD:  reg_period   = val;
      CFG_ON_DELAY:    reg_on_dly   = val;
      CFG_OFF_DELAY:   reg_off_dly  = val;
      CFG_IDLE_TMO:    reg_idle     = val;
      CFG_SHUTDOWN_EN: reg_shutdown = val[0];
      default:         reg_start    = val[0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [DataW-1:0] min_lvl, input logic [DataW-1:0] max_lvl,
                                input logic [DataW-1:0] period, input logic [DataW-1:0] on_dly,
                                input logic [DataW-1:0] off_dly, input logic [DataW-1:0] idle,
                                input bit shutdown, input bit start_en);
    write_reg(CFG_BRIGHT_MIN, min_lvl);
    write_reg(CFG_BRIGHT_MAX, max_lvl);
    write_reg(CFG_PWM_PERIOD, period);
    write_reg(CFG_ON_DELAY, on_dly);
    write_reg(CFG_OFF_DELAY, off_dly);
    write_reg(CFG_IDLE_TMO, idle);
    write_reg(CFG_SHUTDOWN_EN, DataW'(shutdown));
    write_reg(CFG_START_EN, DataW'(start_en));
  endtask

  // The compare value is seeded only on the first PWM start, so hit the zero
  // divisor there, before anything else starts the PWM.
  task automatic test_zero_divisor();
    send_request(ACT_TAIL, 16'd500);
    await_idle();
    write_reg(CFG_BRIGHT_MAX, 16'd0);
    send_request(ACT_TICK, 16'h0000);
    // Init ignores its brightness field; start_enabling is clear so go to disabling.
    send_request(ACT_INIT, 16'hFFFF);
  endtask

  // Full-scale setpoints, alternating bit patterns, and tail, brake and tick at the widest range.
  task automatic test_setpoint_extremes();
    await_idle();
    apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
    send_request(ACT_TICK, 16'h0000);
    send_request(ACT_TAIL, 16'hFFFF);
    send_request(ACT_BRAKE, 16'h0000);
    send_request(ACT_TICK, 16'hFFFF);
    send_request(ACT_TICK, 16'h0000);
    send_request(ACT_TICK, 16'h0000);
    send_request(ACT_TAIL, 16'h5555);
    send_request(ACT_BRAKE, 16'hAAAA);
    send_request(ACT_TICK, 16'h5555);
    send_request(ACT_TAIL, 16'h0000);
    send_request(ACT_BRAKE, 16'h0000);
    // Light off: dim drops but the compare value holds; no shutdown allowed.
    send_request(ACT_TICK, 16'hAAAA);
  endtask

  // Clamp above max, small period, idle timeout that is not a multiple of the tick.
  task automatic test_clamp_and_idle();
    await_idle();
    apply_settings(16'd100, 16'd1000, 16'd7, 16'd30, 16'd20, 16'd25, 1'b1, 1'b0);
    send_request(ACT_TAIL, 16'd5000);
    send_request(ACT_TICK, 16'd0);
    send_request(ACT_TAIL, 16'd100);
    // Countdown 25 -> 15 -> 5 -> 0 (saturates), then shutdown and the off delay.
    repeat (5) send_request(ACT_TICK, 16'd0);
    send_request(ACT_INIT, 16'd0);
  endtask

  // Init into enabling with the countdown still at zero: the first enabled tick
  // shuts the driver off right away, since entering enabled does not reload it.
  task automatic test_init_enabling();
    await_idle();
    write_reg(CFG_START_EN, 16'd1);
    send_request(ACT_INIT, 16'd0);
    repeat (4) send_request(ACT_TICK, 16'd0);
  endtask

  task automatic test_random_traffic();
    int unsigned first_count;
    int unsigned phase_start;
    int unsigned phase_goal;
    int unsigned kind;
    first_count = sent_count;
    while (sent_count - first_count < RANDOM_ITEMS) begin
      await_idle();
      steady_flow = ($urandom_range(0, 3) == 0);
      apply_settings(
        ($urandom_range(0, 9) < 6) ? DataW'($urandom_range(0, 50)) :
          (($urandom_range(0, 4) == 0) ? 16'hFFFF : DataW'($urandom())),
        pick_scale_value(), pick_scale_value(),
        ($urandom_range(0, 4) != 0) ? DataW'($urandom_range(0, 60)) :
                                      DataW'($urandom_range(61, 200)),
        ($urandom_range(0, 4) != 0) ? DataW'($urandom_range(0, 60)) :
                                      DataW'($urandom_range(61, 200)),
        ($urandom_range(0, 4) != 0) ? DataW'($urandom_range(0, 120)) :
                                      DataW'($urandom_range(121, 400)),
        $urandom_range(0, 3) != 0, 1'($urandom()));
      phase_start = sent_count;
      phase_goal  = $urandom_range(120, 250);
      while (sent_count - phase_start < phase_goal) begin
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
          // Hold off until the pipeline is empty, then resume.
          await_idle();
        end else if (kind < 22) begin
          repeat ($urandom_range(1, 8)) send_request(2'($urandom()), DataW'($urandom()));
        end else begin
          // Light session: switch on, ride out the turn-on delay, dim around,
          // go dark and let the idle timeout and turn-off delay run out.
          if (kind < 32) send_request(ACT_INIT, DataW'($urandom()));
          repeat ($urandom_range(1, 3))
            send_request($urandom_range(0, 1) ? ACT_BRAKE : ACT_TAIL, pick_level());
          repeat (reg_on_dly / 10 + $urandom_range(1, 3))
            send_request(ACT_TICK, DataW'($urandom()));
          repeat ($urandom_range(1, 6)) begin
            send_request($urandom_range(0, 1) ? ACT_BRAKE : ACT_TAIL, pick_level());
            send_request(ACT_TICK, DataW'($urandom()));
          end
          send_request(ACT_TAIL, $urandom_range(0, 1) ? 16'd0 :
                                   DataW'($urandom_range(0, reg_min)));
          send_request(ACT_BRAKE, $urandom_range(0, 1) ? 16'd0 :
                                    DataW'($urandom_range(0, reg_min)));
          repeat (reg_idle / 10 + reg_off_dly / 10 + $urandom_range(2, 5))
            send_request(ACT_TICK, DataW'($urandom()));
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  // Long turn-on delay that is not a multiple of the tick: enabled is reached
  // on the hundredth tick, back to back.
  task automatic test_long_turn_on_delay();
    await_idle();
    apply_settings(16'd0, 16'd1000, 16'd1000, 16'd995, 16'hFFFF, 16'd200, 1'b1, 1'b1);
    steady_flow = 1'b1;
    send_request(ACT_INIT, 16'd0);
    send_request(ACT_TAIL, 16'd300);
    repeat (101) send_request(ACT_TICK, 16'd0);
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_BRIGHT_MIN;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    in_action_i     = ACT_TAIL;
    in_brightness_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_zero_divisor();
    test_setpoint_extremes();
    test_clamp_and_idle();
    test_init_enabling();
    test_random_traffic();
    test_long_turn_on_delay();

    // Drain everything, then give the block its latency once more.
    await_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
